// ----- design/gcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// GPU command packet encoder package
// Shared types and constants for the packet encoder pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package gcpe_pkg;
   localparam int unsigned MaxWords = 9;
   localparam int unsigned CntW = 4;

   typedef logic [31:0] word_type;
   typedef word_type [MaxWords-1:0] pkt_type;

   typedef enum logic [4:0] {
      CMD_SH_REG   = 5'd0,  CMD_CX_REG   = 5'd1,  CMD_UC_REG  = 5'd2,
      CMD_IDX_SIZE = 5'd3,  CMD_IDX_BUF  = 5'd4,  CMD_IDX_CNT = 5'd5,
      CMD_NUM_INST = 5'd6,  CMD_DRAW_IDX = 5'd7,  CMD_DRAW_MI = 5'd8,
      CMD_DRAW_AUTO= 5'd9,  CMD_DRAW_OFS = 5'd10, CMD_SET_BASE= 5'd11,
      CMD_DISP_IND = 5'd12, CMD_JUMP     = 5'd13, CMD_REWIND  = 5'd14,
      CMD_PRED     = 5'd15, CMD_REL_MEM  = 5'd16, CMD_EVT_WR  = 5'd17,
      CMD_LOD      = 5'd18, CMD_WAIT_MEM = 5'd19, CMD_DISP_DIR= 5'd20
   } cmd_type;

   localparam logic [31:0] HdrType3    = 32'hc000_0000;
   localparam logic [13:0] HdrLenMask  = 14'h3fff;
   localparam logic [31:0] DispModMask = 32'h0000_a038;
   localparam logic [31:0] DispReqBits = 32'h0000_0041;
   localparam logic [31:0] JumpBase    = 32'h0f20_0000;
   localparam logic [31:0] IdxSizeW1   = 32'h2000_0243;
   localparam logic [31:0] IdxSizeW2   = 32'h0000_0400;
   localparam logic [31:0] IntCtxMask  = 32'h07ff_ffff;
   localparam logic [31:0] LodAddrMask = 32'hffff_ffc0;

   // stage 1 -> stage 2: validity and decoded scalars
   typedef struct packed {
      logic     err;
      logic [CntW-1:0] nwords;
   } ctl_type;

   function automatic word_type mk_header(input logic [CntW-1:0] words,
                                          input logic [7:0] op,
                                          input logic [5:0] rg);
      logic [13:0] len;
      len = 14'({10'd0, words} - 14'd2) & HdrLenMask;
      return HdrType3 | {2'b00, len, op, rg, 2'b00};
   endfunction

   function automatic word_type draw_init(input logic [63:0] m);
      return m[32] ? 32'd0 : ((m[31:0] >> 3) & 32'h20);
   endfunction

   function automatic word_type one_if_zero(input word_type c);
      return (c == 32'd0) ? 32'd1 : c;
   endfunction
endpackage
`default_nettype wire

// ----- design/gcpe_check.sv -----
// ----------------------------------------------------------------------------
// Packet encoder stage 1: validation
// Registers the request and decides error flag and word count.
// ----------------------------------------------------------------------------
`default_nettype none
module gcpe_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_vld,
   input  wire logic [4:0]  cmd,
   input  wire logic [63:0] a1, a2, a3, a4, a5, a6, a7, a8, a9, a10, a11,
   output logic [gcpe_pkg::CntW-1:0] nwords,
   output logic             out_vld,
   output logic [4:0]       cmd_o,
   output logic [63:0]      o1, o2, o3, o4, o5, o6, o7, o8, o9, o10, o11,
   output gcpe_pkg::ctl_type ctl_o
);
   gcpe_pkg::ctl_type ctl_in;
   logic [31:0] l1, l2, l3, l4, l6, l10;

   assign l1 = a1[31:0]; assign l2 = a2[31:0]; assign l3 = a3[31:0];
   assign l4 = a4[31:0]; assign l6 = a6[31:0]; assign l10 = a10[31:0];

   always_comb begin
      ctl_in.err = 1'b0;
      ctl_in.nwords = 4'd1;
      unique case (cmd)
         gcpe_pkg::CMD_SH_REG, gcpe_pkg::CMD_CX_REG, gcpe_pkg::CMD_UC_REG,
         gcpe_pkg::CMD_IDX_SIZE, gcpe_pkg::CMD_DRAW_AUTO, gcpe_pkg::CMD_DISP_IND:
            ctl_in.nwords = 4'd3;
         gcpe_pkg::CMD_IDX_BUF: begin
            ctl_in.nwords = 4'd3;
            ctl_in.err = a1[0];
         end
         gcpe_pkg::CMD_IDX_CNT, gcpe_pkg::CMD_NUM_INST, gcpe_pkg::CMD_REWIND:
            ctl_in.nwords = 4'd2;
         gcpe_pkg::CMD_DRAW_IDX: begin
            ctl_in.nwords = 4'd6;
            ctl_in.err = (a2 == 64'd0) || a2[0];
         end
         gcpe_pkg::CMD_DRAW_MI: begin
            ctl_in.nwords = 4'd9;
            ctl_in.err = (a2 == 64'd0) || (a3 == 64'd0) || a2[0];
         end
         gcpe_pkg::CMD_DRAW_OFS, gcpe_pkg::CMD_LOD, gcpe_pkg::CMD_DISP_DIR:
            ctl_in.nwords = 4'd5;
         gcpe_pkg::CMD_SET_BASE, gcpe_pkg::CMD_JUMP, gcpe_pkg::CMD_PRED:
            ctl_in.nwords = 4'd4;
         gcpe_pkg::CMD_REL_MEM: begin
            ctl_in.nwords = 4'd8;
            ctl_in.err = (l3 > 32'd1) || ((l6 > 32'd3) && (l6 != 32'd5)) ||
                         (l10 > 32'd4);
         end
         gcpe_pkg::CMD_EVT_WR: begin
            ctl_in.nwords = (l1[31:1] == 31'h1c) ? 4'd4 : 4'd2;
            ctl_in.err = l1 > 32'h3f;
         end
         gcpe_pkg::CMD_WAIT_MEM: begin
            ctl_in.nwords = (l1 == 32'd0) ? 4'd7 : 4'd9;
            ctl_in.err = (l1 > 32'd1) || (l2 > 32'd7) || (l3 > 32'd4) ||
                         (l4 > 32'd3);
         end
         default: ctl_in.err = 1'b1;
      endcase
      if (ctl_in.err) ctl_in.nwords = 4'd1;
   end

   assign nwords = ctl_in.nwords;

   logic vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= in_vld;
   end
   always_ff @(posedge clock) begin
      cmd_o <= cmd; ctl_o <= ctl_in;
      o1 <= a1; o2 <= a2; o3 <= a3; o4 <= a4; o5 <= a5; o6 <= a6;
      o7 <= a7; o8 <= a8; o9 <= a9; o10 <= a10; o11 <= a11;
   end
   assign out_vld = vld_ff;
endmodule
`default_nettype wire

// ----- design/gcpe_build.sv -----
// ----------------------------------------------------------------------------
// Packet encoder stage 2: word assembly
// Packs argument fields into the full set of packet words and registers them.
// ----------------------------------------------------------------------------
`default_nettype none
module gcpe_build (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_vld,
   input  wire logic [4:0]  cmd,
   input  wire logic [63:0] a1, a2, a3, a4, a5, a6, a7, a8, a9, a10, a11,
   input  wire gcpe_pkg::ctl_type ctl,
   output logic             out_vld,
   output gcpe_pkg::pkt_type pkt_o,
   output gcpe_pkg::ctl_type ctl_o
);
   gcpe_pkg::pkt_type w;
   logic [31:0] l1, l2, l3, l4, l5, l6, l7, l8, l9, l10, l11;
   logic [31:0] gcr, poll, c;
   logic [63:0] daddr, data;

   assign l1 = a1[31:0]; assign l2 = a2[31:0]; assign l3 = a3[31:0];
   assign l4 = a4[31:0]; assign l5 = a5[31:0]; assign l6 = a6[31:0];
   assign l7 = a7[31:0]; assign l8 = a8[31:0]; assign l9 = a9[31:0];
   assign l10 = a10[31:0]; assign l11 = a11[31:0];

   always_comb begin
      w = '0;
      gcr = l2;
      if (gcr[9:8] == 2'b01) gcr[9] = 1'b1;
      daddr = a5; data = a7;
      if (l10 == 32'd4) begin
         daddr = 64'd0; data = 64'd0;
      end else if (l6 == 32'd5) begin
         data = {32'd0, l9[15:0], l8[15:0]};
      end
      poll = (l8[31:20] != 12'd0) ? 32'hffff : {16'd0, l8[19:4]};
      c = (cmd == gcpe_pkg::CMD_DRAW_OFS) ? l2 : l1;
      unique case (cmd)
         gcpe_pkg::CMD_SH_REG, gcpe_pkg::CMD_CX_REG, gcpe_pkg::CMD_UC_REG: begin
            w[0] = gcpe_pkg::mk_header(4'd3, (cmd == gcpe_pkg::CMD_SH_REG) ? 8'h76 :
                     (cmd == gcpe_pkg::CMD_CX_REG) ? 8'h69 : 8'h79, 6'd0);
            w[1] = {16'd0, l1[15:0]}; w[2] = a1[63:32];
         end
         gcpe_pkg::CMD_IDX_SIZE: begin
            w[0] = gcpe_pkg::mk_header(4'd3, 8'h7a, 6'd0);
            w[1] = gcpe_pkg::IdxSizeW1;
            w[2] = gcpe_pkg::IdxSizeW2 | {24'd0, l2[1:0], 4'd0, l1[1:0]};
         end
         gcpe_pkg::CMD_IDX_BUF: begin
            w[0] = gcpe_pkg::mk_header(4'd3, 8'h26, 6'd0);
            w[1] = l1; w[2] = a1[63:32];
         end
         gcpe_pkg::CMD_IDX_CNT, gcpe_pkg::CMD_NUM_INST: begin
            w[0] = gcpe_pkg::mk_header(4'd2, (cmd == gcpe_pkg::CMD_IDX_CNT) ? 8'h13
                                                                          : 8'h2f, 6'd0);
            w[1] = l1;
         end
         gcpe_pkg::CMD_DRAW_IDX: begin
            w[0] = gcpe_pkg::mk_header(4'd6, 8'h27, 6'd0);
            w[1] = gcpe_pkg::one_if_zero(c); w[2] = l2; w[3] = a2[63:32];
            w[4] = c; w[5] = gcpe_pkg::draw_init(a3);
         end
         gcpe_pkg::CMD_DRAW_MI: begin
            w[0] = gcpe_pkg::mk_header(4'd9, 8'h3a, 6'd0);
            w[1] = l1; w[2] = l2; w[3] = a2[63:32];
            w[4] = gcpe_pkg::one_if_zero(l4); w[5] = l3; w[6] = a3[63:32];
            w[7] = l4; w[8] = gcpe_pkg::draw_init(a5) | 32'h80;
         end
         gcpe_pkg::CMD_DRAW_AUTO: begin
            w[0] = gcpe_pkg::mk_header(4'd3, 8'h2d, 6'd0);
            w[1] = l1; w[2] = gcpe_pkg::draw_init(a2) | 32'd2;
         end
         gcpe_pkg::CMD_DRAW_OFS: begin
            w[0] = gcpe_pkg::mk_header(4'd5, 8'h35, 6'd0);
            w[1] = gcpe_pkg::one_if_zero(c); w[2] = l1; w[3] = c;
            w[4] = gcpe_pkg::draw_init(a3);
         end
         gcpe_pkg::CMD_SET_BASE: begin
            w[0] = gcpe_pkg::mk_header(4'd4, 8'h11, 6'd0) | {l1[30:0], 1'b0};
            w[1] = 32'd1; w[2] = {l2[31:3], 3'd0}; w[3] = a2[63:32];
         end
         gcpe_pkg::CMD_DISP_IND: begin
            w[0] = gcpe_pkg::mk_header(4'd3, 8'h16, 6'd0);
            w[1] = l1; w[2] = (l2 & gcpe_pkg::DispModMask) | gcpe_pkg::DispReqBits;
         end
         gcpe_pkg::CMD_JUMP: begin
            w[0] = gcpe_pkg::mk_header(4'd4, 8'h3f, 6'd0);
            w[1] = {l3[31:2], 2'd0}; w[2] = a3[63:32];
            w[3] = gcpe_pkg::JumpBase | {2'd0, l2[1:0], 7'd0, l1[0], l4[19:0]};
         end
         gcpe_pkg::CMD_REWIND: begin
            w[0] = gcpe_pkg::mk_header(4'd2, 8'h59, 6'd0);
            w[1] = {l1[0], 31'd0};
         end
         gcpe_pkg::CMD_PRED: begin
            w[0] = gcpe_pkg::mk_header(4'd4, 8'h20, 6'd0);
            w[1] = {13'd0, l2[2:0], 3'd0, l3[0], 3'd0, l1[0], 8'd0};
            w[2] = {l4[31:4], 4'd0}; w[3] = a4[63:32];
         end
         gcpe_pkg::CMD_REL_MEM: begin
            w[0] = gcpe_pkg::mk_header(4'd8, 8'h10, 6'h18);
            w[1] = {5'd0, l4[1:0], 1'b0, gcr[11:0],
                    (l1 >= 32'h2f) ? 4'd6 : 4'd5, 2'd0, l1[5:0]};
            w[2] = {l6[2:0], 2'd0, l10[2:0], 6'd0, l3[1:0], 16'd0};
            w[3] = {daddr[31:2], 2'd0}; w[4] = daddr[63:32];
            w[5] = data[31:0]; w[6] = data[63:32];
            w[7] = l11 & gcpe_pkg::IntCtxMask;
         end
         gcpe_pkg::CMD_EVT_WR: begin
            if (l1[31:1] == 31'h1c) begin
               w[0] = gcpe_pkg::mk_header(4'd4, 8'h46, 6'd0);
               w[1] = 32'h100 | l1; w[2] = {l2[31:3], 3'd0}; w[3] = a2[63:32];
            end else begin
               w[0] = gcpe_pkg::mk_header(4'd2, 8'h46, 6'd0);
               w[1] = ((l1 == 32'd7) || (l1 == 32'd15) || (l1 == 32'd16)) ?
                      (32'h400 | l1) : l1;
            end
         end
         gcpe_pkg::CMD_LOD: begin
            w[0] = gcpe_pkg::mk_header(4'd5, 8'h8e, 6'd0);
            w[1] = l3; w[2] = l2 & gcpe_pkg::LodAddrMask; w[3] = a2[63:32];
            w[4] = {2'd0, l1[1:0], 8'd0, l6[0], l5[0], l4[7:0], l7[7:0], 2'd0};
         end
         gcpe_pkg::CMD_WAIT_MEM: begin
            if (l1 == 32'd0) begin
               w[0] = gcpe_pkg::mk_header(4'd7, 8'h10, 6'h0a);
               w[1] = {l5[31:2], 2'd0}; w[2] = {14'd0, a5[49:32]};
               w[3] = l7; w[4] = l6;
               w[5] = {5'd0, l4[1:0], 15'd0, l3[1:0], l3[3:2], 1'b0, 1'b1, 1'b0,
                       l2[2:0]};
               w[6] = poll;
            end else begin
               w[0] = gcpe_pkg::mk_header(4'd9, 8'h10, 6'h16);
               w[1] = {l5[31:3], 3'd0}; w[2] = {14'd0, a5[49:32]};
               w[3] = l7; w[4] = a7[63:32]; w[5] = l6; w[6] = a6[63:32];
               w[7] = {5'd0, l4[1:0], 16'd0, l3[0], l3[2:1], 1'b0, 1'b1, 1'b0,
                       l2[2:0]};
               w[8] = poll;
            end
         end
         gcpe_pkg::CMD_DISP_DIR: begin
            w[0] = gcpe_pkg::mk_header(4'd5, 8'h15, 6'd0);
            w[1] = l1; w[2] = l2; w[3] = l3;
            w[4] = (l4 & gcpe_pkg::DispModMask) | gcpe_pkg::DispReqBits;
         end
         default: w = '0;
      endcase
      if (ctl.err) w = '0;
   end

   logic vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= in_vld;
   end
   always_ff @(posedge clock) begin
      pkt_o <= w; ctl_o <= ctl;
   end
   assign out_vld = vld_ff;
endmodule
`default_nettype wire

// ----- design/gcpe_emit.sv -----
// ----------------------------------------------------------------------------
// Packet encoder stage 3: word serializer
// Holds one packet and sends one word per cycle, marking the final word.
// ----------------------------------------------------------------------------
`default_nettype none
module gcpe_emit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_vld,
   input  wire gcpe_pkg::pkt_type pkt,
   input  wire gcpe_pkg::ctl_type ctl,
   output logic             strobe,
   output logic [31:0]      word,
   output logic             last,
   output logic             status
);
   gcpe_pkg::pkt_type pkt_ff;
   logic [gcpe_pkg::CntW-1:0] idx_ff, idx_in, n_ff;
   logic act_ff, act_in, err_ff;
   logic final_word;

   assign final_word = act_ff && (idx_ff == n_ff - 4'd1);

   always_comb begin
      act_in = act_ff;
      idx_in = idx_ff;
      if (in_vld) begin
         act_in = 1'b1;
         idx_in = '0;
      end else if (final_word) begin
         act_in = 1'b0;
      end else if (act_ff) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         act_ff <= act_in;
         idx_ff <= idx_in;
      end
   end
   always_ff @(posedge clock) begin
      if (in_vld) begin
         pkt_ff <= pkt; n_ff <= ctl.nwords; err_ff <= ctl.err;
      end
   end

   assign strobe = act_ff;
   assign word   = pkt_ff[idx_ff];
   assign last   = final_word;
   assign status = err_ff;
endmodule
`default_nettype wire

// ----- design/gpu_command_packet_encoder.sv -----
// A request is registered in gcpe_check, then in gcpe_build, then in the gcpe_emit
// serializer, which puts the first word on the result ports; the rest follow one word per cycle.
// Throughput: a packet of N words (1..9) books the output for its words; busy opens so
// the next packet's first word directly follows, and one-word packets go every cycle.
// Reset clears all valid bits, the booking count and the serializer.
// The receiver cannot stall: rsp_strobe marks each word for one cycle.
// ----------------------------------------------------------------------------
// GPU command packet encoder
// Builds type-3 command packets and streams them as 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none
module gpu_command_packet_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [4:0]  req_cmd,
   input  wire logic [63:0] req_arg1, req_arg2, req_arg3, req_arg4, req_arg5, req_arg6,
   input  wire logic [63:0] req_arg7, req_arg8, req_arg9, req_arg10, req_arg11,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_word,
   output logic             rsp_last,
   output logic             rsp_status
);
   logic v1, v2, take;
   logic [4:0] c1;
   logic [63:0] b1, b2, b3, b4, b5, b6, b7, b8, b9, b10, b11;
   gcpe_pkg::ctl_type k1, k2;
   gcpe_pkg::pkt_type p2;
   logic [gcpe_pkg::CntW-1:0] req_n, book_ff, book_in;

   // book_ff counts the cycles, from this one on, until the output is free of
   // every word already admitted (two front stages plus the words themselves).
   // A new packet can enter when its first word would land right after them.
   assign busy = book_ff > 4'd3;
   assign take = start && !busy;

   always_comb begin
      book_in = book_ff;
      if (take) begin
         book_in = req_n + 4'd2;
      end else if (book_ff != '0) begin
         book_in = book_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) book_ff <= '0;
      else book_ff <= book_in;
   end

   gcpe_check u_check (
      .clock(clock), .reset(reset), .in_vld(take), .cmd(req_cmd),
      .a1(req_arg1), .a2(req_arg2), .a3(req_arg3), .a4(req_arg4), .a5(req_arg5),
      .a6(req_arg6), .a7(req_arg7), .a8(req_arg8), .a9(req_arg9), .a10(req_arg10),
      .a11(req_arg11), .nwords(req_n), .out_vld(v1), .cmd_o(c1),
      .o1(b1), .o2(b2), .o3(b3), .o4(b4), .o5(b5), .o6(b6), .o7(b7), .o8(b8),
      .o9(b9), .o10(b10), .o11(b11), .ctl_o(k1));

   gcpe_build u_build (
      .clock(clock), .reset(reset), .in_vld(v1), .cmd(c1),
      .a1(b1), .a2(b2), .a3(b3), .a4(b4), .a5(b5), .a6(b6), .a7(b7), .a8(b8),
      .a9(b9), .a10(b10), .a11(b11), .ctl(k1),
      .out_vld(v2), .pkt_o(p2), .ctl_o(k2));

   gcpe_emit u_emit (
      .clock(clock), .reset(reset), .in_vld(v2), .pkt(p2), .ctl(k2),
      .strobe(rsp_strobe), .word(rsp_word), .last(rsp_last),
      .status(rsp_status));
endmodule
`default_nettype wire
